// ===== sv/bgr_pkg.sv =====
// Shared types and constants for the block group reverser.
// Used by block_group_reverser and its bench; depends on nothing.
`default_nettype none

package bgr_pkg;

	localparam int MAX_GROUP_DEF = 64;
	localparam int VALUE_W       = 32;
	localparam int GROUP_SIZE_W  = 7;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      list_end;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic                      run_last;
		logic                      out_end;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

`default_nettype wire

// ===== sv/bgr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the read register holds while read enable is low.
`default_nettype none

module bgr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/block_group_reverser.sv =====
// Block group reverser: buffers a value stream in groups and emits each full group reversed;
// a group cut short by list_end comes out in input order. A group of n results drains at one
// result per cycle while out_stall is low, from the group RAM read port, the first result
// appearing in the cycle after the read starts.
// Input stalls while a group drains. Reset clears control, group_size to 1; RAM is not cleared.
// Depends on bgr_pkg and bgr_ram.
`default_nettype none

module block_group_reverser #(
	parameter int MAX_GROUP = bgr_pkg::MAX_GROUP_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bgr_pkg::GROUP_SIZE_W-1:0]    cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire bgr_pkg::in_item_t                   in_item,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output bgr_pkg::out_item_t                       out_item
);

	import bgr_pkg::*;

	localparam int AW = $clog2(MAX_GROUP);
	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int KW = (CW > GROUP_SIZE_W) ? CW : GROUP_SIZE_W;

	state_t state_q, state_nxt;

	logic [GROUP_SIZE_W-1:0] group_size_q;
	logic [CW-1:0]           fill_q;
	logic [CW-1:0]           fill_nxt;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           rd_addr_q;
	logic                    rev_q;
	logic                    end_q;
	logic                    out_valid_s1;
	logic                    run_last_s1;
	logic                    out_end_s1;

	logic [KW-1:0]      k_eff;
	logic [KW-1:0]      gs_ext;
	logic               accept;
	logic               emit_full;
	logic               emit;
	logic               adv;
	logic               rd_en;
	logic [VALUE_W-1:0] rd_data;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign adv       = !out_valid_s1 || !out_stall;
	assign fill_nxt  = fill_q + CW'(1);

	always_comb begin
		gs_ext = KW'(group_size_q);
		if (gs_ext == '0) begin
			k_eff = KW'(1);
		end else if (gs_ext > KW'(MAX_GROUP)) begin
			k_eff = KW'(MAX_GROUP);
		end else begin
			k_eff = gs_ext;
		end
	end

	assign emit_full = KW'(fill_nxt) >= k_eff;
	assign emit      = emit_full || in_item.list_end;

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		rd_en     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && emit) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				rd_en = adv;
				if (adv && cnt_q == CW'(1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_W'(1);
			fill_q       <= '0;
			cnt_q        <= '0;
			rd_addr_q    <= '0;
			rev_q        <= 1'b0;
			end_q        <= 1'b0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				group_size_q <= cfg_data;
			end
			if (accept) begin
				fill_q <= emit ? '0 : fill_nxt;
				if (emit) begin
					cnt_q     <= fill_nxt;
					rd_addr_q <= emit_full ? fill_q[AW-1:0] : '0;
					rev_q     <= emit_full;
					end_q     <= in_item.list_end;
				end
			end
			if (rd_en) begin
				cnt_q        <= cnt_q - CW'(1);
				rd_addr_q    <= rev_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
				out_valid_s1 <= 1'b1;
			end else if (out_valid_s1 && !out_stall) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			run_last_s1 <= (cnt_q == CW'(1));
			out_end_s1  <= (cnt_q == CW'(1)) && end_q;
		end
	end

	bgr_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(MAX_GROUP)
	) u_group_ram (
		.clk  (clk),
		.we   (accept),
		.waddr(fill_q[AW-1:0]),
		.wdata(in_item.value),
		.re   (rd_en),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	assign out_valid          = out_valid_s1;
	assign out_item.out_value = rd_data;
	assign out_item.run_last  = run_last_s1;
	assign out_item.out_end   = out_end_s1;

endmodule

`default_nettype wire
